>>> sv/dgrt_pkg.sv
`timescale 1ns / 1ps

package dgrt_pkg;

   // default store extent
   localparam int DEF_MAX_MAP_WIDTH  = 64;
   localparam int DEF_MAX_MAP_HEIGHT = 64;

   localparam int CELL_W      = 6;
   localparam int POS_W       = 16;
   localparam int FRAC_W      = 10;
   localparam int DELTA_W     = 24;
   localparam int FIRST_W     = 24;   // first side distance never exceeds the delta range
   localparam int SIDE_W      = 32;
   localparam int DIM_W       = 7;
   localparam int COORD_W     = 9;    // signed walk coordinate, -1 .. 127
   localparam int OUT_COORD_W = 8;
   localparam int STEP_W      = 8;
   localparam int FACE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'b1;

   localparam logic REQ_MAP_WRITE = 1'b0;
   localparam logic REQ_CAST      = 1'b1;

   localparam logic [FACE_W-1:0] FACE_EAST  = 2'd0;
   localparam logic [FACE_W-1:0] FACE_WEST  = 2'd1;
   localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd2;
   localparam logic [FACE_W-1:0] FACE_NORTH = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_WALL  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT = 2'd2;

   typedef struct packed {
      logic                req_type;
      logic [CELL_W-1:0]   cell_x;
      logic [CELL_W-1:0]   cell_y;
      logic                cell_is_wall;
      logic [CELL_W-1:0]   start_x;
      logic [CELL_W-1:0]   start_y;
      logic                neg_x;
      logic                neg_y;
      logic [DELTA_W-1:0]  delta_x;
      logic [DELTA_W-1:0]  delta_y;
      logic [FIRST_W-1:0]  side_x;
      logic [FIRST_W-1:0]  side_y;
   } item_type;

   typedef struct packed {
      logic [OUT_COORD_W-1:0] cell_x;
      logic [OUT_COORD_W-1:0] cell_y;
      logic [FACE_W-1:0]      face;
      logic [STATUS_W-1:0]    status;
      logic [SIDE_W-1:0]      side_x;
      logic [SIDE_W-1:0]      side_y;
      logic [STEP_W-1:0]      steps;
   } result_type;

endpackage

>>> sv/dgrt_front.sv
`timescale 1ns / 1ps

module dgrt_front (
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_type,
   input  logic [dgrt_pkg::CELL_W-1:0]   req_cell_x,
   input  logic [dgrt_pkg::CELL_W-1:0]   req_cell_y,
   input  logic                          req_cell_is_wall,
   input  logic [dgrt_pkg::POS_W-1:0]    req_start_pos_x,
   input  logic [dgrt_pkg::POS_W-1:0]    req_start_pos_y,
   input  logic                          req_dir_x_negative,
   input  logic                          req_dir_y_negative,
   input  logic [dgrt_pkg::DELTA_W-1:0]  req_delta_x,
   input  logic [dgrt_pkg::DELTA_W-1:0]  req_delta_y,
   input  logic                          queue_full,
   input  logic                          clearing,
   output logic                          queue_push,
   output dgrt_pkg::item_type            item
);
   import dgrt_pkg::*;

   localparam logic [FRAC_W:0] ONE = (FRAC_W+1)'(1 << FRAC_W);

   logic [FRAC_W:0]         span_x;
   logic [FRAC_W:0]         span_y;
   logic [FRAC_W+DELTA_W:0] prod_x;
   logic [FRAC_W+DELTA_W:0] prod_y;

   assign req_full   = queue_full || clearing;
   assign queue_push = req_push && !req_full;

   // first side distance: distance to the first grid line along each axis
   always_comb begin
      span_x = req_dir_x_negative ? {1'b0, req_start_pos_x[FRAC_W-1:0]}
                                  : ONE - {1'b0, req_start_pos_x[FRAC_W-1:0]};
      span_y = req_dir_y_negative ? {1'b0, req_start_pos_y[FRAC_W-1:0]}
                                  : ONE - {1'b0, req_start_pos_y[FRAC_W-1:0]};
      prod_x = span_x * req_delta_x;
      prod_y = span_y * req_delta_y;

      item.req_type     = req_type;
      item.cell_x       = req_cell_x;
      item.cell_y       = req_cell_y;
      item.cell_is_wall = req_cell_is_wall;
      item.start_x      = req_start_pos_x[POS_W-1:FRAC_W];
      item.start_y      = req_start_pos_y[POS_W-1:FRAC_W];
      item.neg_x        = req_dir_x_negative;
      item.neg_y        = req_dir_y_negative;
      item.delta_x      = req_delta_x;
      item.delta_y      = req_delta_y;
      item.side_x       = prod_x[FRAC_W+FIRST_W-1:FRAC_W];
      item.side_y       = prod_y[FRAC_W+FIRST_W-1:FRAC_W];
   end

endmodule

>>> sv/dgrt_queue.sv
`timescale 1ns / 1ps

module dgrt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dgrt_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output dgrt_pkg::item_type  pop_item,
   output logic                empty
);
   import dgrt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/dgrt_back.sv
`timescale 1ns / 1ps

module dgrt_back #(
   parameter int MAX_MAP_WIDTH  = dgrt_pkg::DEF_MAX_MAP_WIDTH,
   parameter int MAX_MAP_HEIGHT = dgrt_pkg::DEF_MAX_MAP_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        queue_empty,
   input  dgrt_pkg::item_type          queue_item,
   output logic                        queue_pop,
   input  logic [dgrt_pkg::DIM_W-1:0]  cols,
   input  logic [dgrt_pkg::DIM_W-1:0]  rows,
   output logic                        clearing,
   input  logic                        rsp_pop,
   output logic                        rsp_valid,
   output dgrt_pkg::result_type        result
);
   import dgrt_pkg::*;

   localparam int DEPTH  = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_STEP  = 2'd2;

   logic                       mem_ff [DEPTH];

   logic [1:0]                 state_ff, state_in;
   logic [ADDR_W-1:0]          clr_addr_ff, clr_addr_in;
   logic signed [COORD_W-1:0]  gx_ff, gx_in;
   logic signed [COORD_W-1:0]  gy_ff, gy_in;
   logic [SIDE_W-1:0]          sx_ff, sx_in;
   logic [SIDE_W-1:0]          sy_ff, sy_in;
   logic [DELTA_W-1:0]         dx_ff, dx_in;
   logic [DELTA_W-1:0]         dy_ff, dy_in;
   logic                       neg_x_ff, neg_x_in;
   logic                       neg_y_ff, neg_y_in;
   logic [STEP_W-1:0]          steps_ff, steps_in;
   logic [FACE_W-1:0]          face_ff, face_in;
   logic                       took_x_ff, took_x_in;
   logic                       rd_x_ff, rd_y_ff;
   logic                       res_valid_ff, res_valid_in;
   result_type                 res_ff, res_in;

   logic signed [COORD_W-1:0]  gx_next;
   logic signed [COORD_W-1:0]  gy_next;
   logic [ADDR_W-1:0]          rd_addr_x;
   logic [ADDR_W-1:0]          rd_addr_y;
   logic                       rd_en;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic                       wr_data;
   logic [STEP_W-1:0]          limit;
   logic                       out_of_map;
   logic                       wall;
   logic                       finish;
   logic [STATUS_W-1:0]        status;
   logic                       out_free;
   logic [SIDE_W:0]            sum_x;
   logic [SIDE_W:0]            sum_y;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
      cell_addr = ADDR_W'(int'(y) * MAX_MAP_WIDTH + int'(x));
   endfunction

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = res_valid_ff;
   assign result    = res_ff;

   // candidate cells for both possible steps, read ahead of the decision
   assign gx_next   = neg_x_ff ? gx_ff - COORD_W'(1) : gx_ff + COORD_W'(1);
   assign gy_next   = neg_y_ff ? gy_ff - COORD_W'(1) : gy_ff + COORD_W'(1);
   assign rd_addr_x = cell_addr(gx_next, gy_ff);
   assign rd_addr_y = cell_addr(gx_ff, gy_next);

   assign limit      = STEP_W'(cols) + STEP_W'(rows);
   assign out_of_map = gx_ff[COORD_W-1] || gy_ff[COORD_W-1]
                    || (gx_ff[COORD_W-2:0] >= (COORD_W-1)'(cols))
                    || (gy_ff[COORD_W-2:0] >= (COORD_W-1)'(rows));
   assign wall       = took_x_ff ? rd_x_ff : rd_y_ff;
   assign out_free   = !res_valid_ff || rsp_pop;
   assign sum_x      = {1'b0, sx_ff} + (SIDE_W+1)'(dx_ff);
   assign sum_y      = {1'b0, sy_ff} + (SIDE_W+1)'(dy_ff);

   // check the cell just entered: bounds first, then wall, then step limit
   always_comb begin
      finish = 1'b0;
      status = STATUS_LIMIT;
      if (steps_ff == '0) begin
         finish = (limit == '0);
      end else if (out_of_map) begin
         finish = 1'b1;
         status = STATUS_OUT;
      end else if (wall) begin
         finish = 1'b1;
         status = STATUS_WALL;
      end else if (steps_ff == limit) begin
         finish = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      steps_in     = steps_ff;
      face_in      = face_ff;
      took_x_in    = took_x_ff;
      res_valid_in = res_valid_ff && !rsp_pop;
      res_in       = res_ff;
      queue_pop    = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               if (queue_item.req_type == REQ_CAST) begin
                  gx_in     = COORD_W'(queue_item.start_x);
                  gy_in     = COORD_W'(queue_item.start_y);
                  sx_in     = SIDE_W'(queue_item.side_x);
                  sy_in     = SIDE_W'(queue_item.side_y);
                  dx_in     = queue_item.delta_x;
                  dy_in     = queue_item.delta_y;
                  neg_x_in  = queue_item.neg_x;
                  neg_y_in  = queue_item.neg_y;
                  steps_in  = '0;
                  face_in   = FACE_EAST;
                  took_x_in = 1'b0;
                  state_in  = ST_STEP;
               end else begin
                  // drop writes beyond the store
                  wr_en   = (int'(queue_item.cell_x) < MAX_MAP_WIDTH)
                         && (int'(queue_item.cell_y) < MAX_MAP_HEIGHT);
                  wr_addr = cell_addr(COORD_W'(queue_item.cell_x),
                                      COORD_W'(queue_item.cell_y));
                  wr_data = queue_item.cell_is_wall;
               end
            end
         end
         ST_STEP: begin
            if (finish) begin
               // hold the walk until the result register is free
               if (out_free) begin
                  res_valid_in  = 1'b1;
                  res_in.cell_x = gx_ff[OUT_COORD_W-1:0];
                  res_in.cell_y = gy_ff[OUT_COORD_W-1:0];
                  res_in.face   = face_ff;
                  res_in.status = status;
                  res_in.side_x = sx_ff;
                  res_in.side_y = sy_ff;
                  res_in.steps  = steps_ff;
                  state_in      = ST_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               steps_in = steps_ff + 1'b1;
               if (sx_ff < sy_ff) begin
                  sx_in     = sum_x[SIDE_W] ? '1 : sum_x[SIDE_W-1:0];
                  gx_in     = gx_next;
                  face_in   = neg_x_ff ? FACE_WEST : FACE_EAST;
                  took_x_in = 1'b1;
               end else begin
                  sy_in     = sum_y[SIDE_W] ? '1 : sum_y[SIDE_W-1:0];
                  gy_in     = gy_next;
                  face_in   = neg_y_ff ? FACE_NORTH : FACE_SOUTH;
                  took_x_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gx_ff     <= gx_in;
      gy_ff     <= gy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      neg_x_ff  <= neg_x_in;
      neg_y_ff  <= neg_y_in;
      steps_ff  <= steps_in;
      face_ff   <= face_in;
      took_x_ff <= took_x_in;
      res_ff    <= res_in;
   end

   // wall store: one write port, two read ports with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_x_ff <= mem_ff[rd_addr_x];
         rd_y_ff <= mem_ff[rd_addr_y];
      end
   end

endmodule

>>> sv/dda_grid_ray_traversal.sv
`timescale 1ns / 1ps

// Grid ray traversal over a one-bit wall map.
// Request side is a queue write port: drive the item on req_* and raise req_push;
// it is taken at a clock edge where req_full is low. req_type selects a map
// write (sets one cell wall or open, no response) or a ray cast (one response).
// Responses come out of a queue read port: while rsp_empty is low the oldest
// result sits on rsp_*, and rsp_pop takes it.
// Map extent is set through csr_* (index 0 width, 1 height, both 64 after
// reset); csr_ready is always high. Write it only while the block is idle.
// A four-entry queue sits between the request decode and the walker.
// A cast is loaded from the queue, then takes one grid step at a time, at most
// width + height steps, and then checks the last cell. The walker takes one
// step per cycle, limited by the registered read of the wall store.
// After reset the wall store is swept to open, one cell per cycle over all
// MAX_MAP_WIDTH * MAX_MAP_HEIGHT cells (4096 by default); req_full stays
// high meanwhile. A finished result waits in the response register while
// rsp_pop is low; the walker then holds, and requests pile up until full.
module dda_grid_ray_traversal #(
   parameter int MAX_MAP_WIDTH  = dgrt_pkg::DEF_MAX_MAP_WIDTH,
   parameter int MAX_MAP_HEIGHT = dgrt_pkg::DEF_MAX_MAP_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_type,
   input  logic [dgrt_pkg::CELL_W-1:0]            req_cell_x,
   input  logic [dgrt_pkg::CELL_W-1:0]            req_cell_y,
   input  logic                                   req_cell_is_wall,
   input  logic [dgrt_pkg::POS_W-1:0]             req_start_pos_x,
   input  logic [dgrt_pkg::POS_W-1:0]             req_start_pos_y,
   input  logic                                   req_dir_x_negative,
   input  logic                                   req_dir_y_negative,
   input  logic [dgrt_pkg::DELTA_W-1:0]           req_delta_x,
   input  logic [dgrt_pkg::DELTA_W-1:0]           req_delta_y,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [dgrt_pkg::OUT_COORD_W-1:0] rsp_hit_cell_x,
   output logic signed [dgrt_pkg::OUT_COORD_W-1:0] rsp_hit_cell_y,
   output logic [dgrt_pkg::FACE_W-1:0]            rsp_wall_face,
   output logic [dgrt_pkg::STATUS_W-1:0]          rsp_hit_status,
   output logic [dgrt_pkg::SIDE_W-1:0]            rsp_final_side_x,
   output logic [dgrt_pkg::SIDE_W-1:0]            rsp_final_side_y,
   output logic [dgrt_pkg::STEP_W-1:0]            rsp_steps_taken,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dgrt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dgrt_pkg::DIM_W-1:0]             csr_data
);
   import dgrt_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] width_eff;
   logic [DIM_W-1:0] height_eff;
   logic             queue_push;
   logic             queue_full;
   logic             queue_pop;
   logic             queue_empty;
   logic             clearing;
   logic             rsp_valid;
   item_type         push_item;
   item_type         pop_item;
   result_type       result;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAP_WIDTH:  width_in  = csr_data;
            CSR_MAP_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamp the extent in use to the store size
   assign width_eff  = (int'(width_ff) > MAX_MAP_WIDTH)
                     ? DIM_W'(MAX_MAP_WIDTH) : width_ff;
   assign height_eff = (int'(height_ff) > MAX_MAP_HEIGHT)
                     ? DIM_W'(MAX_MAP_HEIGHT) : height_ff;

   dgrt_front u_front (
      .req_push           (req_push),
      .req_full           (req_full),
      .req_type           (req_type),
      .req_cell_x         (req_cell_x),
      .req_cell_y         (req_cell_y),
      .req_cell_is_wall   (req_cell_is_wall),
      .req_start_pos_x    (req_start_pos_x),
      .req_start_pos_y    (req_start_pos_y),
      .req_dir_x_negative (req_dir_x_negative),
      .req_dir_y_negative (req_dir_y_negative),
      .req_delta_x        (req_delta_x),
      .req_delta_y        (req_delta_y),
      .queue_full         (queue_full),
      .clearing           (clearing),
      .queue_push         (queue_push),
      .item               (push_item)
   );

   dgrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_item  (pop_item),
      .empty     (queue_empty)
   );

   dgrt_back #(
      .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
      .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_item  (pop_item),
      .queue_pop   (queue_pop),
      .cols        (width_eff),
      .rows        (height_eff),
      .clearing    (clearing),
      .rsp_pop     (rsp_pop),
      .rsp_valid   (rsp_valid),
      .result      (result)
   );

   assign rsp_empty        = !rsp_valid;
   assign rsp_hit_cell_x   = signed'(result.cell_x);
   assign rsp_hit_cell_y   = signed'(result.cell_y);
   assign rsp_wall_face    = result.face;
   assign rsp_hit_status   = result.status;
   assign rsp_final_side_x = result.side_x;
   assign rsp_final_side_y = result.side_y;
   assign rsp_steps_taken  = result.steps;

   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("request side open while the wall store is being cleared");

   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_steps_taken <= (STEP_W'(width_eff) + STEP_W'(height_eff))))
      else $error("walk ran past the step limit");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_hit_status == STATUS_WALL || rsp_hit_status == STATUS_OUT
                      || rsp_hit_status == STATUS_LIMIT))
      else $error("undefined hit status");

   a_no_step_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_steps_taken == '0)
         |-> (rsp_hit_status == STATUS_LIMIT && rsp_wall_face == FACE_EAST))
      else $error("stepless cast reported a wall or a crossed face");

endmodule
